@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the Microwire read master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define MWR_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ sv/mwr_pkg.sv @@
// Types and constants of the Microwire EEPROM read master.
package mwr_pkg;

  localparam int unsigned DataBits       = 16;
  localparam int unsigned MaxAddressBits = 8;
  localparam int unsigned MinAddressBits = 6;
  localparam int unsigned CmdBits        = MaxAddressBits + 3;
  localparam int unsigned BitCntW        = 4;
  localparam int unsigned TickW          = 10;
  localparam int unsigned AddrLenW       = 4;
  localparam int unsigned CfgDataW       = 10;

  localparam logic [AddrLenW-1:0] AddrLenReset    = 4'd6;
  localparam logic [TickW-1:0]    PhaseTicksReset = 10'd4;

  // Register indexes of the configuration port.
  localparam logic CfgAddressLength = 1'b0;
  localparam logic CfgPhaseTicks    = 1'b1;

  typedef struct packed {
    logic                chip_select;
    logic                shift_clock;
    logic                data_to_eeprom;
    logic                busy_res;
    logic                word_valid;
    logic [DataBits-1:0] read_word;
  } mwr_res_t;

endpackage

@@ sv/mwr_if.sv @@
// Valid/ready channel interfaces for the input tick and the pin result words.
interface mwr_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] word_address;
  logic       eeprom_data_out;

  modport source (output valid, start_req, word_address, eeprom_data_out, input ready);
  modport sink   (input valid, start_req, word_address, eeprom_data_out, output ready);
endinterface

interface mwr_out_if;
  logic        valid;
  logic        ready;
  logic        chip_select;
  logic        shift_clock;
  logic        data_to_eeprom;
  logic        busy_res;
  logic        word_valid;
  logic [15:0] read_word;

  modport source (output valid, chip_select, shift_clock, data_to_eeprom, busy_res,
                  word_valid, read_word, input ready);
  modport sink   (input valid, chip_select, shift_clock, data_to_eeprom, busy_res,
                  word_valid, read_word, output ready);
endinterface

@@ sv/microwire_eeprom_read_master_top.sv @@
// Microwire EEPROM read master: one input word per tick gives one pin-level result word.
// Each input word is one tick of the pin sequencer and yields exactly one result word, at a
// rate of one word per clock cycle: the sequencer state and the result register update
// together on every accepted word, and a new word is taken whenever the result register is
// empty or being drained. A read runs deselect, len+5 command bits (len = address_length
// clamped to 6..8), a gap, 16 data bits, each pin phase held for phase_ticks ticks (0 counts
// as 1); word_valid marks the tick the sequence ends, and a start while busy is dropped.
`include "assert_macros.svh"

module microwire_eeprom_read_master_top import mwr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mwr_in_if.sink              in_ch,
  mwr_out_if.source           out_ch
);

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhDesel    = 3'd1;
  localparam logic [2:0] PhCmdLow   = 3'd2;
  localparam logic [2:0] PhCmdHigh  = 3'd3;
  localparam logic [2:0] PhGap      = 3'd4;
  localparam logic [2:0] PhDataHigh = 3'd5;
  localparam logic [2:0] PhDataLow  = 3'd6;

  logic [AddrLenW-1:0] abits_q;
  logic [TickW-1:0]    phase_ticks_q;

  logic [2:0]          phase_q, phase_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [CmdBits-1:0]  cmd_q, cmd_d;
  logic [DataBits-1:0] data_q, data_d;

  mwr_res_t            res_q, res_d;
  logic                out_vld_q;
  logic                accept;

  logic [AddrLenW-1:0] len_sat;
  logic [TickW-1:0]    limit;
  logic [TickW-1:0]    tick_inc;
  logic                phase_end;
  logic [7:0]          addr_mask;
  logic                done;

  assign in_ch.ready = !out_vld_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abits_q       <= AddrLenReset;
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAddressLength: abits_q       <= cfg_data_i[AddrLenW-1:0];
        CfgPhaseTicks:    phase_ticks_q <= cfg_data_i[TickW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (abits_q < AddrLenW'(MinAddressBits)) begin
      len_sat = AddrLenW'(MinAddressBits);
    end else if (abits_q > AddrLenW'(MaxAddressBits)) begin
      len_sat = AddrLenW'(MaxAddressBits);
    end else begin
      len_sat = abits_q;
    end
  end

  assign addr_mask = 8'((9'd1 << len_sat) - 9'd1);
  assign limit     = (phase_ticks_q == '0) ? TickW'(1) : phase_ticks_q;
  assign tick_inc  = tick_q + TickW'(1);
  assign phase_end = (tick_inc >= limit) || (tick_inc == '0);

  // Sequencer next state for one tick.
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    tick_d    = tick_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    done      = 1'b0;
    if (phase_q == PhIdle) begin
      if (in_ch.start_req) begin
        cmd_d     = (CmdBits'(3'b110) << len_sat) | CmdBits'(in_ch.word_address & addr_mask);
        bit_cnt_d = BitCntW'(len_sat) + BitCntW'(4);
        tick_d    = '0;
        phase_d   = PhDesel;
      end
    end else begin
      tick_d = tick_inc;
      if (phase_end) begin
        tick_d = '0;
        case (phase_q)
          PhDesel:   phase_d = PhCmdLow;
          PhCmdLow:  phase_d = PhCmdHigh;
          PhCmdHigh: begin
            if (bit_cnt_q == '0) begin
              phase_d = PhGap;
            end else begin
              bit_cnt_d = bit_cnt_q - BitCntW'(1);
              phase_d   = PhCmdLow;
            end
          end
          PhGap: begin
            bit_cnt_d = BitCntW'(DataBits - 1);
            phase_d   = PhDataHigh;
          end
          PhDataHigh: begin
            // Sample on the tick the clock returns low.
            data_d  = {data_q[DataBits-2:0], in_ch.eeprom_data_out};
            phase_d = PhDataLow;
          end
          PhDataLow: begin
            if (bit_cnt_q == '0) begin
              phase_d = PhIdle;
              done    = 1'b1;
            end else begin
              bit_cnt_d = bit_cnt_q - BitCntW'(1);
              phase_d   = PhDataHigh;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  // Pin levels from the state after this tick.
  always_comb begin
    res_d                = '0;
    res_d.chip_select    = (phase_d != PhIdle) && (phase_d != PhDesel);
    res_d.shift_clock    = (phase_d == PhCmdHigh) || (phase_d == PhDataHigh);
    if (((phase_d == PhCmdLow) || (phase_d == PhCmdHigh)) &&
        (bit_cnt_d < BitCntW'(CmdBits))) begin
      res_d.data_to_eeprom = cmd_d[bit_cnt_d];
    end
    res_d.busy_res   = (phase_d != PhIdle);
    res_d.word_valid = done;
    res_d.read_word  = data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      bit_cnt_q <= '0;
      tick_q    <= '0;
      cmd_q     <= '0;
      data_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        bit_cnt_q <= bit_cnt_d;
        tick_q    <= tick_d;
        cmd_q     <= cmd_d;
        data_q    <= data_d;
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.chip_select    = res_q.chip_select;
  assign out_ch.shift_clock    = res_q.shift_clock;
  assign out_ch.data_to_eeprom = res_q.data_to_eeprom;
  assign out_ch.busy_res       = res_q.busy_res;
  assign out_ch.word_valid     = res_q.word_valid;
  assign out_ch.read_word      = res_q.read_word;

  `MWR_ASSERT(a_done_not_busy, !(out_vld_q && res_q.word_valid && res_q.busy_res), "word_valid while busy")
  `MWR_ASSERT(a_sel_when_busy, !(out_vld_q && res_q.chip_select && !res_q.busy_res), "chip select while idle")
  `MWR_ASSERT(a_clk_when_sel, !(out_vld_q && res_q.shift_clock && !res_q.chip_select), "shift clock while deselected")
  `MWR_ASSERT_NEXT(a_hold_state, !accept, $stable(phase_q) && $stable(tick_q), "state moved without a word")
  `MWR_ASSERT_NEXT(a_result_loads, accept, out_vld_q, "accepted word gave no result")

endmodule
